>>> sv/lz78pc_pkg.sv
package lz78pc_pkg;

  localparam int PC_W  = 13;
  localparam int SYM_W = 8;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_HASH,
    ST_TAB,
    ST_CLEAR
  } state_t;

  typedef enum logic {
    CMD_SYMBOL = 1'b0,
    CMD_CLEAR  = 1'b1
  } cmd_t;

  typedef struct packed {
    logic             command;
    logic [SYM_W-1:0] symbol;
    logic             end_of_string;
  } in_t;

  typedef struct packed {
    logic [PC_W-1:0] phrase_count;
    logic            new_phrase;
    logic [PC_W-1:0] matched_id;
    logic            dictionary_full;
  } out_t;

endpackage

>>> sv/lz78pc_ram.sv
module lz78pc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/lz78_phrase_complexity_core.sv
// Each symbol reads the hash slot it maps to, and stops there when the slot is empty; when it
// holds a hit or a stale entry left from before a clear, a phrase table read follows, and every
// further slot of the linear probe adds a hash slot read, then a phrase table read to confirm
// the slot is live.
// The result is registered; a new transaction is taken once the previous one is finished.
// Reset is synchronous and active low; afterwards a pass over all 2**($clog2(MAX_PHRASES)+1)
// entries (8192 by default) zeroes the hash memory while in_ready stays low.
module lz78_phrase_complexity_core #(
  parameter int MAX_PHRASES = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lz78pc_pkg::in_t   in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output lz78pc_pkg::out_t  out_data
);

  import lz78pc_pkg::*;

  localparam int ID_W       = $clog2(MAX_PHRASES + 1);
  localparam int TAB_AW     = $clog2(MAX_PHRASES);
  localparam int HASH_AW    = $clog2(MAX_PHRASES) + 1;
  localparam int HASH_DEPTH = 2 ** HASH_AW;
  localparam int KEY_W      = ID_W + SYM_W;
  localparam int SLOT_W     = ID_W + KEY_W;
  localparam int NCHUNK     = (KEY_W + HASH_AW - 1) / HASH_AW;
  localparam logic [ID_W-1:0] MAX_ID = ID_W'(MAX_PHRASES);

  function automatic logic [HASH_AW-1:0] hash_key(input logic [KEY_W-1:0] k);
    logic [HASH_AW-1:0] h;
    h = '0;
    for (int c = 0; c < NCHUNK; c++) begin
      h = h ^ HASH_AW'(k >> (c * HASH_AW));
    end
    return h;
  endfunction

  state_t state_r, state_nxt;
  logic [ID_W-1:0]    cur_r, cur_nxt;
  logic [ID_W-1:0]    count_r, count_nxt;
  logic [SYM_W-1:0]   sym_r, sym_nxt;
  logic               eos_r, eos_nxt;
  logic [HASH_AW-1:0] probe_r, probe_nxt;
  logic [HASH_AW-1:0] init_r, init_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_t               out_r;

  logic               hash_we, hash_re;
  logic [HASH_AW-1:0] hash_waddr, hash_raddr;
  logic [SLOT_W-1:0]  hash_wdata, hash_rdata;
  logic               tab_we, tab_re;
  logic [TAB_AW-1:0]  tab_waddr, tab_raddr;
  logic [KEY_W-1:0]   tab_wdata, tab_rdata;

  logic [ID_W-1:0]    slot_id;
  logic [KEY_W-1:0]   slot_key, search_key;
  logic               slot_dead, slot_live, tab_hit, out_free, can_store;

  logic               res_load, res_new, res_full;
  logic [ID_W-1:0]    res_count, res_id;
  logic [ID_W+PC_W-1:0] res_count_wide, res_id_wide;

  lz78pc_ram #(.WIDTH(SLOT_W), .DEPTH(HASH_DEPTH)) u_hash_ram (
    .clk   (clk),
    .we    (hash_we),
    .waddr (hash_waddr),
    .wdata (hash_wdata),
    .re    (hash_re),
    .raddr (hash_raddr),
    .rdata (hash_rdata)
  );

  lz78pc_ram #(.WIDTH(KEY_W), .DEPTH(MAX_PHRASES)) u_tab_ram (
    .clk   (clk),
    .we    (tab_we),
    .waddr (tab_waddr),
    .wdata (tab_wdata),
    .re    (tab_re),
    .raddr (tab_raddr),
    .rdata (tab_rdata)
  );

  assign slot_id    = hash_rdata[SLOT_W-1:KEY_W];
  assign slot_key   = hash_rdata[KEY_W-1:0];
  assign search_key = {cur_r, sym_r};
  assign slot_dead  = (slot_id == '0) || (slot_id > count_r);
  assign slot_live  = (tab_rdata == slot_key);
  assign tab_hit    = (tab_rdata == search_key) && (slot_key == search_key);
  assign out_free   = !out_valid_r || out_ready;
  assign can_store  = (count_r < MAX_ID);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT: begin
        if (init_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_data.command == CMD_CLEAR) ? ST_CLEAR : ST_HASH;
        end
      end
      ST_HASH: begin
        if (!slot_dead) begin
          state_nxt = ST_TAB;
        end else if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_TAB: begin
        if (!tab_hit && slot_live) begin
          state_nxt = ST_HASH;
        end else if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cur_nxt    = cur_r;
    count_nxt  = count_r;
    sym_nxt    = sym_r;
    eos_nxt    = eos_r;
    probe_nxt  = probe_r;
    init_nxt   = init_r;
    hash_we    = 1'b0;
    hash_waddr = probe_r;
    hash_wdata = {ID_W'(count_r + ID_W'(1)), search_key};
    hash_re    = 1'b0;
    hash_raddr = probe_r;
    tab_we     = 1'b0;
    tab_waddr  = count_r[TAB_AW-1:0];
    tab_wdata  = search_key;
    tab_re     = 1'b0;
    tab_raddr  = TAB_AW'(slot_id - ID_W'(1));
    res_load   = 1'b0;
    res_new    = 1'b0;
    res_full   = 1'b0;
    res_count  = count_r;
    res_id     = '0;
    in_ready   = 1'b0;
    case (state_r)
      ST_INIT: begin
        hash_we    = 1'b1;
        hash_waddr = init_r;
        hash_wdata = '0;
        init_nxt   = init_r + HASH_AW'(1);
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          sym_nxt = in_data.symbol;
          eos_nxt = in_data.end_of_string;
          if (in_data.command == CMD_SYMBOL) begin
            hash_re    = 1'b1;
            hash_raddr = hash_key({cur_r, in_data.symbol});
            probe_nxt  = hash_raddr;
          end
        end
      end
      ST_HASH, ST_TAB: begin
        if (state_r == ST_HASH && !slot_dead) begin
          tab_re = 1'b1;
        end else if (state_r == ST_TAB && !tab_hit && slot_live) begin
          hash_re    = 1'b1;
          hash_raddr = probe_r + HASH_AW'(1);
          probe_nxt  = hash_raddr;
        end else if (out_free) begin
          res_load = 1'b1;
          if (state_r == ST_TAB && tab_hit) begin
            res_id  = slot_id;
            cur_nxt = eos_r ? '0 : slot_id;
          end else begin
            cur_nxt = '0;
            if (can_store) begin
              hash_we   = 1'b1;
              tab_we    = 1'b1;
              count_nxt = ID_W'(count_r + ID_W'(1));
              res_count = count_nxt;
              res_id    = count_nxt;
              res_new   = 1'b1;
            end else begin
              res_full = 1'b1;
            end
          end
        end
      end
      ST_CLEAR: begin
        if (out_free) begin
          res_load  = 1'b1;
          count_nxt = '0;
          cur_nxt   = '0;
          res_count = '0;
        end
      end
      default: ;
    endcase
    out_valid_nxt = res_load || (out_valid_r && !out_ready);
  end

  assign res_count_wide = {{PC_W{1'b0}}, res_count};
  assign res_id_wide    = {{PC_W{1'b0}}, res_id};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      cur_r       <= '0;
      count_r     <= '0;
      init_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      count_r     <= count_nxt;
      init_r      <= init_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sym_r   <= sym_nxt;
    eos_r   <= eos_nxt;
    probe_r <= probe_nxt;
    if (res_load) begin
      out_r.phrase_count    <= res_count_wide[PC_W-1:0];
      out_r.new_phrase      <= res_new;
      out_r.matched_id      <= res_id_wide[PC_W-1:0];
      out_r.dictionary_full <= res_full;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> sv/lz78pc_checker.sv
module lz78pc_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input lz78pc_pkg::out_t out_data
);

  import lz78pc_pkg::*;

  a_new_phrase_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.new_phrase |->
      !out_data.dictionary_full && (out_data.matched_id == out_data.phrase_count)
      && (out_data.phrase_count != '0))
    else $error("New phrase transaction carries an inconsistent id or count.");

  a_full_no_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.dictionary_full |->
      (out_data.matched_id == '0) && !out_data.new_phrase)
    else $error("Full dictionary transaction reports a stored phrase.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("Stalled result transaction changed or was dropped.");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("Ports are not quiet after reset.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("A second input transaction was offered before the first one finished.");

endmodule

bind lz78_phrase_complexity_core lz78pc_checker u_lz78pc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import lz78pc_pkg::*;

  localparam int MAX_PHRASES   = 4096;
  localparam int RANDOM_ITEMS  = 860;
  localparam int IDLE_LIMIT    = 30000;
  localparam int HOLD_OFF      = 400;
  localparam int HOLD_AFTER    = 150;
  localparam int DRAIN_CYCLES  = 20;

  class phrase_scoreboard;
    int unsigned max_phrases;
    int unsigned stored_cnt;
    int unsigned cur_id;
    int unsigned phrase_of[bit [20:0]];
    out_t        expected_q[$];
    int          errors;

    function new(int unsigned maxp);
      max_phrases = maxp;
      stored_cnt  = 0;
      cur_id      = 0;
      errors      = 0;
    endfunction

    function void note_input(in_t t);
      out_t        e;
      bit [20:0]   pair;
      e = '0;
      if (t.command == CMD_CLEAR) begin
        phrase_of.delete();
        stored_cnt = 0;
        cur_id     = 0;
      end else begin
        pair = {cur_id[12:0], t.symbol};
        if (phrase_of.exists(pair)) begin
          cur_id       = phrase_of[pair];
          e.matched_id = cur_id[12:0];
        end else if (stored_cnt < max_phrases) begin
          stored_cnt      = stored_cnt + 1;
          phrase_of[pair] = stored_cnt;
          e.new_phrase    = 1'b1;
          e.matched_id    = stored_cnt[12:0];
          cur_id          = 0;
        end else begin
          e.dictionary_full = 1'b1;
          cur_id            = 0;
        end
        if (t.end_of_string) begin
          cur_id = 0;
        end
        e.phrase_count = stored_cnt[12:0];
      end
      expected_q.push_back(e);
    endfunction

    function void check_result(out_t r);
      out_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected result transaction: %p", r);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (r.phrase_count !== e.phrase_count) begin
        $error("phrase_count: expected %0d, actual %0d", e.phrase_count, r.phrase_count);
        errors++;
      end
      if (r.new_phrase !== e.new_phrase) begin
        $error("new_phrase: expected %0d, actual %0d", e.new_phrase, r.new_phrase);
        errors++;
      end
      if (r.matched_id !== e.matched_id) begin
        $error("matched_id: expected %0d, actual %0d", e.matched_id, r.matched_id);
        errors++;
      end
      if (r.dictionary_full !== e.dictionary_full) begin
        $error("dictionary_full: expected %0d, actual %0d", e.dictionary_full,
               r.dictionary_full);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  phrase_scoreboard sb;
  int items_sent;
  int results_seen;
  int burst_left;
  int idle_cycles;

  lz78_phrase_complexity_core #(
    .MAX_PHRASES(MAX_PHRASES)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic in_t make_item(cmd_t c, logic [7:0] s, logic e);
    in_t t;
    t.command       = c;
    t.symbol        = s;
    t.end_of_string = e;
    return t;
  endfunction

  function automatic int next_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 3) == 0) begin
      burst_left = $urandom_range(50, 150);
    end else begin
      burst_left = $urandom_range(1, 12);
    end
    return $urandom_range(1, 8);
  endfunction

  task automatic send(input in_t t);
    int gap;
    @(negedge clk);
    in_valid = 1'b1;
    in_data  = t;
    do begin
      @(posedge clk);
    end while (!in_ready);
    sb.note_input(t);
    items_sent++;
    gap = next_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_string();
    int         len;
    bit         narrow;
    bit         broken;
    logic [7:0] alph[4];
    logic [7:0] sym;
    logic       eos;
    len    = $urandom_range(1, 14);
    narrow = ($urandom_range(0, 3) != 0);
    broken = ($urandom_range(0, 9) == 0);
    foreach (alph[i]) alph[i] = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 39) == 0) begin
      send(make_item(CMD_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
    end
    for (int i = 0; i < len; i++) begin
      sym = narrow ? alph[$urandom_range(0, 3)] : 8'($urandom_range(0, 255));
      eos = broken ? 1'($urandom_range(0, 1)) : (i == len - 1);
      send(make_item(CMD_SYMBOL, sym, eos));
    end
  endtask

  initial begin
    bit held;
    int mode;
    int phase_cnt;
    held      = 1'b0;
    mode      = 0;
    phase_cnt = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && results_seen >= HOLD_AFTER) begin
        held      = 1'b1;
        out_ready = 1'b0;
        repeat (HOLD_OFF) @(negedge clk);
      end
      if (phase_cnt == 0) begin
        mode      = $urandom_range(0, 3);
        phase_cnt = $urandom_range(16, 96);
      end
      phase_cnt--;
      case (mode)
        0: out_ready = 1'b1;
        1: out_ready = 1'($urandom_range(0, 1));
        2: out_ready = (phase_cnt % 4 == 0);
        default: out_ready = ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(out_data);
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int start;
    sb           = new(MAX_PHRASES);
    items_sent   = 0;
    results_seen = 0;
    burst_left   = 0;
    idle_cycles  = 0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send(make_item(CMD_SYMBOL, 8'h00, 1'b0));
    send(make_item(CMD_SYMBOL, 8'h00, 1'b0));
    send(make_item(CMD_SYMBOL, 8'h00, 1'b0));
    send(make_item(CMD_SYMBOL, 8'hFF, 1'b1));
    send(make_item(CMD_SYMBOL, 8'hFF, 1'b0));
    send(make_item(CMD_SYMBOL, 8'h00, 1'b1));
    send(make_item(CMD_SYMBOL, 8'h00, 1'b0));
    send(make_item(CMD_SYMBOL, 8'h00, 1'b1));
    send(make_item(CMD_SYMBOL, 8'h00, 1'b0));
    send(make_item(CMD_CLEAR, 8'hAA, 1'b1));
    send(make_item(CMD_SYMBOL, 8'h00, 1'b0));
    send(make_item(CMD_SYMBOL, 8'h55, 1'b0));
    send(make_item(CMD_SYMBOL, 8'hAA, 1'b1));
    send(make_item(CMD_SYMBOL, 8'h00, 1'b0));
    send(make_item(CMD_SYMBOL, 8'h55, 1'b1));
    send(make_item(CMD_CLEAR, 8'h00, 1'b0));

    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      send_string();
    end

    send(make_item(CMD_CLEAR, 8'hFF, 1'b1));
    repeat (10) send_string();

    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/lz78pc_pkg.sv
sv/lz78pc_ram.sv
sv/lz78_phrase_complexity_core.sv
sv/lz78pc_checker.sv
tb/sv/tb_top.sv
